### rtl/fir_so_pkg.sv
// Package for the FIR filter with shift and offset.
// Holds sizes, register and operation codes, item types and sequencer states.
// No dependencies.
`default_nettype none

package fir_so_pkg;

	localparam int TAPS = 64;
	localparam int POS_W = $clog2(TAPS);
	localparam int SMP_W = 16;
	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W = PROD_W + POS_W;
	localparam int RES_W = ACC_W + 1;
	localparam int TAP_W = 6;
	localparam int SHIFT_W = 6;
	localparam int OFFSET_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd32;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd24;

	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 1'b1;

	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef struct packed {
		logic operation;
		logic signed [SMP_W-1:0] sample_word;
		logic [TAP_W-1:0] tap_number;
		logic signed [SMP_W-1:0] tap_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] filtered_value;
		logic overflow;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_SHIFT,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/fir_filter_shift_offset.sv
// FIR filter top level: sample history and coefficient table in two RAMs,
// one shared multiply-accumulate stepped over the taps by a sequencer.
// A sample transaction is accepted only in idle and gives one result; in_stall stays
// high until that result has moved to the output register, so a new sample waits while
// the single multiplier walks the taps; a coefficient load gives no result.
// Reset (arst_n low) clears history and coefficients through per-entry valid bits.
`default_nettype none

module fir_filter_shift_offset (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fir_so_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output fir_so_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [fir_so_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fir_so_pkg::CFG_DATA_W-1:0] cfg_data
);

	import fir_so_pkg::*;

	state_t st_q, st_d;
	logic [POS_W-1:0] k_q;
	logic [POS_W-1:0] rd_pos_q;
	logic [POS_W-1:0] newest_q;
	logic [TAPS-1:0] hist_vld_q;
	logic [TAPS-1:0] coef_vld_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sh_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [SHIFT_W-1:0] shift_q;
	logic out_valid_q;
	out_item_t out_data_q;
	logic rd_vld_s1, hv_s1, cv_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic mul_vld_s2;

	logic in_acc, smp_acc, ld_acc;
	logic issue, load_out, out_free;
	logic [SMP_W-1:0] hist_rdata, coef_rdata;
	logic signed [SMP_W-1:0] hop, cop;
	logic signed [RES_W-1:0] res;
	logic ovf;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && !in_stall;
	assign smp_acc = in_acc && (in_data.operation == OP_FILTER);
	assign ld_acc = in_acc && (in_data.operation == OP_LOAD)
		&& (int'(in_data.tap_number) < TAPS);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (smp_acc) st_d = ST_RUN;
			end
			ST_RUN: begin
				if (k_q == POS_W'(TAPS - 1)) st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!rd_vld_s1 && !mul_vld_s2) st_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				st_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		issue = 1'b0;
		load_out = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RUN: begin
				issue = 1'b1;
			end
			ST_OUT: begin
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	fir_so_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_hist_ram (
		.clk(clk),
		.we(smp_acc),
		.waddr(newest_q),
		.wdata(in_data.sample_word),
		.re(issue),
		.raddr(rd_pos_q),
		.rdata(hist_rdata)
	);

	fir_so_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_coef_ram (
		.clk(clk),
		.we(ld_acc),
		.waddr(POS_W'(in_data.tap_number)),
		.wdata(in_data.tap_value),
		.re(issue),
		.raddr(k_q),
		.rdata(coef_rdata)
	);

	assign hop = hv_s1 ? signed'(hist_rdata) : '0;
	assign cop = cv_s1 ? signed'(coef_rdata) : '0;

	assign res = RES_W'(sh_q) + RES_W'(offset_q);
	assign ovf = !((&res[RES_W-1:SMP_W-1]) || !(|res[RES_W-1:SMP_W-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= '0;
			rd_pos_q <= '0;
			newest_q <= '0;
			hist_vld_q <= '0;
			coef_vld_q <= '0;
			offset_q <= OFFSET_RESET;
			shift_q <= SHIFT_RESET;
			out_valid_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OUTPUT_OFFSET: offset_q <= cfg_data;
					REG_SHIFT_AMOUNT: shift_q <= cfg_data[SHIFT_W-1:0];
					default: begin
					end
				endcase
			end
			if (ld_acc) begin
				coef_vld_q[POS_W'(in_data.tap_number)] <= 1'b1;
			end
			if (smp_acc) begin
				hist_vld_q[newest_q] <= 1'b1;
				newest_q <= (newest_q == '0) ? POS_W'(TAPS - 1) : newest_q - 1'b1;
				rd_pos_q <= newest_q;
				k_q <= '0;
			end else if (issue) begin
				rd_pos_q <= (rd_pos_q == POS_W'(TAPS - 1)) ? '0 : rd_pos_q + 1'b1;
				k_q <= k_q + 1'b1;
			end
			rd_vld_s1 <= issue;
			mul_vld_s2 <= rd_vld_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hv_s1 <= hist_vld_q[rd_pos_q];
			cv_s1 <= coef_vld_q[k_q];
		end
		prod_s2 <= hop * cop;
		if (smp_acc) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (st_q == ST_SHIFT) begin
			sh_q <= acc_q >>> shift_q;
		end
		if (load_out) begin
			out_data_q.filtered_value <= res[SMP_W-1:0];
			out_data_q.overflow <= ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (st_q == ST_IDLE))
		else $error("input transaction taken outside idle");

	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (!rd_vld_s1 && !mul_vld_s2))
		else $error("multiply pipeline busy while idle");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN && k_q == POS_W'(TAPS - 1)) |=> (st_q == ST_DRAIN))
		else $error("tap walk did not end after last tap");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_data_q)))
		else $error("pending result overwritten");

	a_sample_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> (st_q == ST_RUN && k_q == '0))
		else $error("sample did not start tap walk");

endmodule

`default_nettype wire

### rtl/fir_so_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no dependencies.
`default_nettype none

module fir_so_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
